// ===== rtl/mclp_pkg.sv =====
// ============================================================================
// mclp_pkg
// Shared types and codes for the motion command line parser.
// ============================================================================
package mclp_pkg;

    // Input beat selector (tuser on the slave side)
    typedef enum logic [1:0] {
        MODE_CHAR   = 2'd0,
        MODE_DONE   = 2'd1,
        MODE_START  = 2'd2,
        MODE_STOP   = 2'd3
    } t_mode;

    // Result kind (tuser on the master side)
    typedef enum logic [2:0] {
        KIND_MOVE    = 3'd0,
        KIND_FEED    = 3'd1,
        KIND_DWELL   = 3'd2,
        KIND_EXEC    = 3'd3,
        KIND_RESTART = 3'd4,
        KIND_END     = 3'd5,
        KIND_FETCH   = 3'd6,
        KIND_HALT    = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PARSE = 2'd1,
        PH_EXEC  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        PK_NONE  = 3'd0,
        PK_SKIP  = 3'd1,
        PK_DWELL = 3'd2,
        PK_AXIS  = 3'd3,
        PK_FEED  = 3'd4
    } t_pend;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  axis;
        logic        negative;
        logic [31:0] value;
        logic [7:0]  line_number;
        logic        last;
    } t_result;

    // Up to two results produced by one input beat, in delivery order
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_emit;

    function automatic logic [31:0] times_ten(input logic [31:0] v);
        times_ten = (v << 3) + (v << 1);
    endfunction

endpackage

// ===== rtl/mclp_core.sv =====
// ============================================================================
// mclp_core
// Parser state and per-beat decode: up to two results per accepted beat.
// ============================================================================
module mclp_core
    import mclp_pkg::*;
#(
    parameter int unsigned LINE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_mode      i_mode,
    input  logic [7:0] i_char,
    output t_emit      o_emit
);

    localparam int unsigned COL_W = $clog2(LINE_WIDTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH - 1);

    t_phase           r_phase,     n_phase;
    logic [COL_W-1:0] r_col,       n_col;
    logic [31:0]      r_acc,       n_acc;
    t_pend            r_pend,      n_pend;
    logic [2:0]       r_paxis,     n_paxis;
    logic             r_sign,      n_sign;
    logic             r_neg,       n_neg;
    logic [2:0]       r_last_axis, n_last_axis;
    logic             r_has,       n_has;
    logic             r_skip,      n_skip;
    logic [7:0]       r_cur,       n_cur;

    // values after the character itself, before end-of-line handling
    logic [31:0] m_acc;
    t_pend       m_pend;
    logic [2:0]  m_paxis, m_last_axis;
    logic        m_sign, m_neg, m_has, m_skip;

    logic        consumed, restart, ax_hit;
    logic [2:0]  ax_idx;
    t_result     fin, tail;
    logic        fin_vld, tail_vld;

    function automatic logic emits(input t_pend p);
        emits = (p == PK_DWELL) || (p == PK_AXIS) || (p == PK_FEED);
    endfunction

    function automatic t_result finish(input t_pend p, input logic [2:0] pax,
                                       input logic neg, input logic [31:0] acc,
                                       input logic [2:0] lax);
        t_result r;
        r = '0;
        case (p)
            PK_DWELL: begin
                r.kind  = KIND_DWELL;
                r.value = times_ten(acc);
            end
            PK_AXIS: begin
                r.kind     = KIND_MOVE;
                r.axis     = pax;
                r.negative = neg;
                r.value    = acc;
            end
            PK_FEED: begin
                r.kind  = KIND_FEED;
                r.axis  = lax;
                r.value = acc;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        unique case (i_char)
            CH_X:    begin ax_hit = 1'b1; ax_idx = 3'd0; end
            CH_Y:    begin ax_hit = 1'b1; ax_idx = 3'd1; end
            CH_Z:    begin ax_hit = 1'b1; ax_idx = 3'd2; end
            CH_A:    begin ax_hit = 1'b1; ax_idx = 3'd3; end
            CH_B:    begin ax_hit = 1'b1; ax_idx = 3'd4; end
            CH_C:    begin ax_hit = 1'b1; ax_idx = 3'd5; end
            default: begin ax_hit = 1'b0; ax_idx = 3'd0; end
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_col       = r_col;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_paxis     = r_paxis;
        n_sign      = r_sign;
        n_neg       = r_neg;
        n_last_axis = r_last_axis;
        n_has       = r_has;
        n_skip      = r_skip;
        n_cur       = r_cur;

        m_acc       = r_acc;
        m_pend      = r_pend;
        m_paxis     = r_paxis;
        m_sign      = r_sign;
        m_neg       = r_neg;
        m_last_axis = r_last_axis;
        m_has       = r_has;
        m_skip      = r_skip;

        consumed = 1'b0;
        restart  = 1'b0;
        fin      = '0;
        fin_vld  = 1'b0;
        tail     = '0;
        tail_vld = 1'b0;

        unique case (i_mode)
            MODE_CHAR: begin
                if (r_phase == PH_PARSE) begin
                    if (i_char != CH_SPACE) m_has = 1'b1;
                    if (!r_skip) begin
                        consumed = r_sign && (i_char == CH_MINUS);
                        if (r_sign) begin
                            m_sign = 1'b0;
                            if (consumed) m_neg = 1'b1;
                        end
                        if (!consumed) begin
                            if (r_pend != PK_NONE) begin
                                if (i_char == CH_SPACE) begin
                                    // space closes the number
                                    fin     = finish(r_pend, r_paxis, r_neg, r_acc,
                                                     r_last_axis);
                                    fin_vld = emits(r_pend);
                                    m_pend  = PK_NONE;
                                    m_sign  = 1'b0;
                                    m_neg   = 1'b0;
                                    m_acc   = '0;
                                end else begin
                                    m_acc = times_ten(r_acc) + 32'(i_char[3:0]);
                                end
                            end else if (ax_hit) begin
                                m_pend      = PK_AXIS;
                                m_paxis     = ax_idx;
                                m_last_axis = ax_idx;
                                m_sign      = 1'b1;
                                m_neg       = 1'b0;
                                m_acc       = '0;
                            end else if (i_char == CH_N) begin
                                m_pend = PK_SKIP;
                                m_acc  = '0;
                            end else if (i_char == CH_W) begin
                                m_pend = PK_DWELL;
                                m_acc  = '0;
                            end else if (i_char == CH_F) begin
                                m_pend = PK_FEED;
                                m_acc  = '0;
                            end else if (i_char == CH_M) begin
                                restart = 1'b1;
                            end else if (i_char == CH_SEMI) begin
                                m_skip = 1'b1;
                            end
                        end
                    end

                    if (restart) begin
                        // line dropped, next beat is column 0 of line 0
                        n_cur        = '0;
                        n_col        = '0;
                        n_acc        = '0;
                        n_pend       = PK_NONE;
                        n_paxis      = '0;
                        n_sign       = 1'b0;
                        n_neg        = 1'b0;
                        n_has        = 1'b0;
                        n_skip       = 1'b0;
                        tail.kind    = KIND_RESTART;
                        tail_vld     = 1'b1;
                    end else if (r_col >= COL_LAST) begin
                        if (!fin_vld) begin
                            fin     = finish(m_pend, m_paxis, m_neg, m_acc, m_last_axis);
                            fin_vld = emits(m_pend);
                        end
                        n_last_axis = m_last_axis;
                        n_col       = '0;
                        n_acc       = '0;
                        n_pend      = PK_NONE;
                        n_paxis     = '0;
                        n_sign      = 1'b0;
                        n_neg       = 1'b0;
                        n_has       = 1'b0;
                        n_skip      = 1'b0;
                        tail_vld    = 1'b1;
                        if (m_has) begin
                            tail.kind = KIND_EXEC;
                            n_phase   = PH_EXEC;
                        end else begin
                            tail.kind = KIND_END;
                            n_phase   = PH_IDLE;
                            n_cur     = '0;
                        end
                    end else begin
                        n_col       = r_col + COL_W'(1);
                        n_acc       = m_acc;
                        n_pend      = m_pend;
                        n_paxis     = m_paxis;
                        n_sign      = m_sign;
                        n_neg       = m_neg;
                        n_last_axis = m_last_axis;
                        n_has       = m_has;
                        n_skip      = m_skip;
                    end
                end
            end
            MODE_DONE: begin
                if (r_phase == PH_EXEC) begin
                    n_cur            = r_cur + 8'd1;
                    n_col            = '0;
                    n_acc            = '0;
                    n_pend           = PK_NONE;
                    n_paxis          = '0;
                    n_sign           = 1'b0;
                    n_neg            = 1'b0;
                    n_has            = 1'b0;
                    n_skip           = 1'b0;
                    n_phase          = PH_PARSE;
                    tail.kind        = KIND_FETCH;
                    tail.line_number = r_cur + 8'd1;
                    tail_vld         = 1'b1;
                end
            end
            MODE_START: begin
                if (r_phase == PH_IDLE) begin
                    n_cur     = '0;
                    n_col     = '0;
                    n_acc     = '0;
                    n_pend    = PK_NONE;
                    n_paxis   = '0;
                    n_sign    = 1'b0;
                    n_neg     = 1'b0;
                    n_has     = 1'b0;
                    n_skip    = 1'b0;
                    n_phase   = PH_PARSE;
                    tail.kind = KIND_FETCH;
                    tail_vld  = 1'b1;
                end
            end
            MODE_STOP: begin
                n_phase     = PH_IDLE;
                n_cur       = '0;
                n_last_axis = '0;
                n_col       = '0;
                n_acc       = '0;
                n_pend      = PK_NONE;
                n_paxis     = '0;
                n_sign      = 1'b0;
                n_neg       = 1'b0;
                n_has       = 1'b0;
                n_skip      = 1'b0;
                tail.kind   = KIND_HALT;
                tail_vld    = 1'b1;
            end
            default: ;
        endcase
    end

    // pack results in delivery order, flag the final one
    always_comb begin
        o_emit = '0;
        if (fin_vld) begin
            o_emit.r0      = fin;
            o_emit.r1      = tail;
            o_emit.r0.last = !tail_vld;
            o_emit.r1.last = 1'b1;
            o_emit.cnt     = tail_vld ? 2'd2 : 2'd1;
        end else begin
            o_emit.r0      = tail;
            o_emit.r0.last = 1'b1;
            o_emit.cnt     = tail_vld ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_col       <= '0;
            r_acc       <= '0;
            r_pend      <= PK_NONE;
            r_paxis     <= '0;
            r_sign      <= 1'b0;
            r_neg       <= 1'b0;
            r_last_axis <= '0;
            r_has       <= 1'b0;
            r_skip      <= 1'b0;
            r_cur       <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_col       <= n_col;
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_paxis     <= n_paxis;
            r_sign      <= n_sign;
            r_neg       <= n_neg;
            r_last_axis <= n_last_axis;
            r_has       <= n_has;
            r_skip      <= n_skip;
            r_cur       <= n_cur;
        end
    end

endmodule

// ===== rtl/mclp_outq.sv =====
// ============================================================================
// mclp_outq
// Small result queue: writes up to two results a cycle, reads one.
// ============================================================================
module mclp_outq
    import mclp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_emit   i_emit,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]         push_cnt;
    logic               pop;

    assign o_room   = r_cnt <= QCNT_W'(QDEPTH - 2);
    assign o_valid  = r_cnt != '0;
    assign o_data   = r_mem[r_rd];
    assign pop      = o_valid && i_ready;
    assign push_cnt = i_push ? i_emit.cnt : 2'd0;

    always_comb begin
        n_wr  = r_wr + QPTR_W'(push_cnt);
        n_rd  = r_rd + QPTR_W'(pop);
        n_cnt = r_cnt + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) r_mem[r_wr] <= i_emit.r0;
        if (push_cnt == 2'd2) r_mem[r_wr + QPTR_W'(1)] <= i_emit.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/motion_command_line_parser.sv =====
// ============================================================================
// motion_command_line_parser
// Character-serial program line parser for a six-axis stepper controller.
// ============================================================================
//
// channel   dir  tdata                      tuser      tlast
// s_axis    in   char_code[7:0]             mode[1:0]  -
// m_axis    out  axis,negative,value,line   kind[2:0]  final result of beat
//
// Cycles: one input beat per cycle sustained while the result queue has
// room. A beat is decoded combinationally straight out of the input
// register and its 0..2 results land in a 4-entry result queue; the first
// result is offered from the queue, the second once the first is taken.
// A beat leaves the input register only while the queue has room for two
// results, so the queue drain rate sets throughput under back-pressure.
// Reset (synchronous, active low) returns the parser to idle, line 0, and
// empties both the input register and the result queue.
// ============================================================================
module motion_command_line_parser
    import mclp_pkg::*;
#(
    parameter int unsigned LINE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [2:0] axis, [3] negative, [35:4] value,
                                        // [43:36] line_number, [47:44] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast
);

    // input register
    logic       r_in_vld;
    t_mode      r_in_mode;
    logic [7:0] r_in_char;

    logic       s_fire;
    logic       proc_fire;
    logic       q_room;
    t_emit      emit;
    t_result    q_data;

    assign proc_fire     = r_in_vld && q_room;
    assign s_axis_tready = !r_in_vld || proc_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_mode <= t_mode'(s_axis_tuser);
            r_in_char <= s_axis_tdata;
        end
    end

    mclp_core #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_mode  (r_in_mode),
        .i_char  (r_in_char),
        .o_emit  (emit)
    );

    mclp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (proc_fire),
        .i_emit  (emit),
        .o_room  (q_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (q_data)
    );

    assign m_axis_tdata = {4'b0000, q_data.line_number, q_data.value,
                           q_data.negative, q_data.axis};
    assign m_axis_tuser = q_data.kind;
    assign m_axis_tlast = q_data.last;

endmodule

// ===== rtl/mclp_chk.sv =====
// ============================================================================
// mclp_chk
// Port-level checks for the motion command line parser, bound to the top.
// ============================================================================
module mclp_chk
    import mclp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // reset flushes the result queue
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending right after reset");

    // line and sequencing events always close their beat's results
    a_ctrl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_EXEC || m_axis_tuser == KIND_RESTART ||
                          m_axis_tuser == KIND_END || m_axis_tuser == KIND_FETCH ||
                          m_axis_tuser == KIND_HALT)
        |-> m_axis_tlast && m_axis_tdata[35:0] == 36'd0)
        else $error("control result not final or carries data");

    // feed divider names a real axis and no direction
    a_feed_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_FEED
        |-> !m_axis_tdata[3] && m_axis_tdata[2:0] <= 3'd5 && m_axis_tdata[43:36] == 8'd0)
        else $error("bad feed divider result");

    // a non-final result is always followed by the rest of the same beat
    a_nonlast_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of a beat missing");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind motion_command_line_parser mclp_chk u_mclp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
